/* hw/rtl/mspseq_pkg.sv */
package mspseq_pkg;

    // Number of servo channels; the table holds one more entry for the off period.
    localparam int CHANNELS = 18;
    localparam int ENTRIES  = CHANNELS + 1;
    localparam int CH_W     = 5;
    localparam int PORT_W   = 2;
    localparam int MASK_W   = 8;
    localparam int US_W     = 16;
    localparam int TICK_W   = 14;
    localparam int RELOAD_W = 8;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_WR_BOTH    = 2'd1,
        REQ_WR_MASK    = 2'd2,
        REQ_WR_PERIOD  = 2'd3
    } req_t;

    typedef enum logic [PORT_W-1:0] {
        PORT_A = 2'd0,
        PORT_B = 2'd1,
        PORT_C = 2'd2
    } port_t;

    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [TICK_W-1:0] tick_t;

    // Ports are fixed wiring per channel; they are never rewritten.
    function automatic port_t entry_port(input chan_t idx);
        port_t p;
        case (idx)
            5'd0:                         p = PORT_C;
            5'd1, 5'd3, 5'd5:             p = PORT_A;
            5'd2, 5'd4, 5'd6:             p = PORT_B;
            5'd7, 5'd8, 5'd9, 5'd10,
            5'd11, 5'd12, 5'd13, 5'd14:   p = PORT_C;
            5'd15, 5'd16, 5'd17, 5'd18:   p = PORT_B;
            default:                      p = PORT_A;
        endcase
        return p;
    endfunction

    function automatic mask_t default_mask(input chan_t idx);
        mask_t m;
        case (idx)
            5'd0:    m = 8'h00;
            5'd1:    m = 8'h01;
            5'd2:    m = 8'h10;
            5'd3:    m = 8'h04;
            5'd4:    m = 8'h40;
            5'd5:    m = 8'h10;
            5'd6:    m = 8'h80;
            5'd7:    m = 8'h01;
            5'd8:    m = 8'h02;
            5'd9:    m = 8'h04;
            5'd10:   m = 8'h08;
            5'd11:   m = 8'h10;
            5'd12:   m = 8'h20;
            5'd13:   m = 8'h40;
            5'd14:   m = 8'h80;
            5'd15:   m = 8'h08;
            5'd16:   m = 8'h04;
            5'd17:   m = 8'h02;
            5'd18:   m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Default on-times in ticks (microseconds divided by four).
    function automatic tick_t default_period(input chan_t idx);
        tick_t t;
        case (idx)
            5'd0, 5'd1, 5'd4, 5'd7, 5'd9,
            5'd11, 5'd13, 5'd15, 5'd17:      t = 14'd250;
            5'd2, 5'd5:                      t = 14'd375;
            5'd3, 5'd6, 5'd8, 5'd10,
            5'd12, 5'd14, 5'd16, 5'd18:      t = 14'd500;
            default:                         t = 14'd0;
        endcase
        return t;
    endfunction

endpackage

/* hw/rtl/multiplexed_servo_pulse_sequencer_unit.sv */
// Servo pulse sequencer that walks a table of channel entries one pulse at a time.
// Each input transaction is a timer overflow tick or a table write, and each produces
// exactly one output transaction in the next cycle. The whole update for a transaction
// is one pass of short logic into the output register, so a new transaction is taken
// every cycle whenever the output register is empty or being drained in the same cycle.
// The first tick after reset switches off the off-period entry and starts channel 1.
// Long periods count down in chunks of 256 ticks; the last chunk is announced through
// reload_valid with the 8-bit timer preload.
module multiplexed_servo_pulse_sequencer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel[4:0], pin_mask[12:5], period_us[28:13], zero fill
    input  logic [mspseq_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // switched[0], off_port[2:1], off_mask[10:3], on_port[12:11], on_mask[20:13],
    // active_channel[25:21], reload_valid[26], reload_value[34:27], zero fill
    output logic [mspseq_pkg::OUT_DATA_W-1:0]   m_tdata
);

    typedef struct packed {
        logic [4:0]                       pad;
        logic [mspseq_pkg::RELOAD_W-1:0]  reload_value;
        logic                             reload_valid;
        mspseq_pkg::chan_t                active_channel;
        logic [mspseq_pkg::MASK_W-1:0]    on_mask;
        logic [mspseq_pkg::PORT_W-1:0]    on_port;
        logic [mspseq_pkg::MASK_W-1:0]    off_mask;
        logic [mspseq_pkg::PORT_W-1:0]    off_port;
        logic                             switched;
    } result_t;

    mspseq_pkg::chan_t  channel_index_reg, channel_index_next;
    mspseq_pkg::tick_t  remaining_reg, remaining_next;
    mspseq_pkg::mask_t  cur_mask_reg, cur_mask_next;
    mspseq_pkg::mask_t  mask_reg   [mspseq_pkg::ENTRIES];
    mspseq_pkg::tick_t  period_reg [mspseq_pkg::ENTRIES];
    result_t            result_reg, result_next;
    logic               valid_reg;

    logic               accept;
    mspseq_pkg::req_t   req;
    mspseq_pkg::chan_t  in_channel;
    mspseq_pkg::mask_t  in_mask;
    logic [mspseq_pkg::US_W-1:0] in_us;
    logic               tick;
    logic               need_switch;
    logic               ch_ok;
    logic               wr_mask;
    logic               wr_period;
    mspseq_pkg::chan_t  next_idx;
    mspseq_pkg::tick_t  load_ticks;
    logic               last_chunk;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg;

    assign req        = mspseq_pkg::req_t'(s_tuser);
    assign in_channel = s_tdata[4:0];
    assign in_mask    = s_tdata[12:5];
    assign in_us      = s_tdata[28:13];

    assign tick        = (req == mspseq_pkg::REQ_TICK);
    assign need_switch = (remaining_reg == '0);
    assign ch_ok       = (in_channel <= mspseq_pkg::CH_W'(mspseq_pkg::CHANNELS));
    assign wr_mask     = !tick && ch_ok &&
                         (req == mspseq_pkg::REQ_WR_BOTH || req == mspseq_pkg::REQ_WR_MASK);
    assign wr_period   = !tick && ch_ok &&
                         (req == mspseq_pkg::REQ_WR_BOTH || req == mspseq_pkg::REQ_WR_PERIOD);

    assign next_idx   = (channel_index_reg >= mspseq_pkg::CH_W'(mspseq_pkg::CHANNELS)) ?
                        '0 : channel_index_reg + 1'b1;
    assign load_ticks = need_switch ? period_reg[next_idx] : remaining_reg;
    assign last_chunk = (load_ticks[mspseq_pkg::TICK_W-1:8] == '0);

    always_comb
    begin
        channel_index_next = channel_index_reg;
        remaining_next     = remaining_reg;
        cur_mask_next      = cur_mask_reg;
        result_next        = '0;

        if (tick)
        begin
            if (need_switch)
            begin
                result_next.switched = 1'b1;
                result_next.off_port = mspseq_pkg::entry_port(channel_index_reg);
                result_next.off_mask = cur_mask_reg;
                result_next.on_port  = mspseq_pkg::entry_port(next_idx);
                result_next.on_mask  = mask_reg[next_idx];
                channel_index_next   = next_idx;
                cur_mask_next        = mask_reg[next_idx];
            end
            if (last_chunk)
            begin
                // Preload is 256 minus the remainder, taken modulo 256.
                result_next.reload_valid = 1'b1;
                result_next.reload_value = 8'd0 - load_ticks[7:0];
                remaining_next           = '0;
            end
            else
            begin
                remaining_next = load_ticks - mspseq_pkg::TICK_W'(256);
            end
        end
        else if (wr_mask && in_channel == channel_index_reg)
        begin
            // Keep the copy of the active entry's mask in step with the table.
            cur_mask_next = in_mask;
        end

        result_next.active_channel = channel_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_index_reg <= '0;
            remaining_reg     <= '0;
            cur_mask_reg      <= mspseq_pkg::default_mask('0);
            valid_reg         <= 1'b0;
            for (int i = 0; i < mspseq_pkg::ENTRIES; i++)
            begin
                mask_reg[i]   <= mspseq_pkg::default_mask(mspseq_pkg::CH_W'(i));
                period_reg[i] <= mspseq_pkg::default_period(mspseq_pkg::CH_W'(i));
            end
        end
        else
        begin
            if (accept)
            begin
                channel_index_reg <= channel_index_next;
                remaining_reg     <= remaining_next;
                cur_mask_reg      <= cur_mask_next;
                if (wr_mask)
                begin
                    mask_reg[in_channel] <= in_mask;
                end
                if (wr_period)
                begin
                    period_reg[in_channel] <= in_us[mspseq_pkg::US_W-1:2];
                end
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        channel_index_reg <= mspseq_pkg::CH_W'(mspseq_pkg::CHANNELS))
        else $error("channel index beyond the last entry");

    a_no_switch_with_time_left: assert property (@(posedge clk) disable iff (!rst_n)
        accept && tick && remaining_reg != '0 |=> !result_reg.switched)
        else $error("switched while ticks were still left");

    a_reload_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && tick && last_chunk |=> remaining_reg == '0 && result_reg.reload_valid)
        else $error("last chunk did not reload and clear the count");

    a_write_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !tick |=> $stable(channel_index_reg) && $stable(remaining_reg)
                            && !result_reg.switched && !result_reg.reload_valid)
        else $error("table write disturbed the sequencing state");

endmodule
